@@ rtl/core/tmcw_pkg.sv @@
// shared types and constants for the text-mode console writer
// used by tmcw_ctrl, tmcw_dp and text_mode_console_writer_core; no dependencies
package tmcw_pkg;

  // field widths of the stream items
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int POS_W    = 11;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // cell contents
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CELL_W-1:0] INIT_CELL  = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // register map
  localparam int APB_ADDR_W = 3;
  localparam logic REG_COLOR = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT     = 2'd0,
    CMD_NEWLINE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_READ    = 2'd3
  } tmcw_cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;    // capture the accepted command
    logic exec;       // perform put / new line / read, update cursor
    logic fill_wr;    // write a fill cell at the sweep address
    logic fill_init;  // fill with the reset cell rather than a blank
    logic copy_rd;    // read the scroll source at the sweep address
    logic load_out;   // load the result register
  } tmcw_ctl_t;

  // datapath to controller
  typedef struct packed {
    tmcw_cmd_e cmd;   // command being worked on
    logic      scroll; // the command ends in a scroll
    logic      out_free; // result register can take a new result
  } tmcw_sts_t;

endpackage

@@ rtl/core/tmcw_ctrl.sv @@
// command sequencer of the text-mode console writer: reset fill, command
// dispatch, scroll and clear sweeps; depends on tmcw_pkg
module tmcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELL_COUNT = COLUMNS * ROWS,
  localparam int AW = $clog2(CELL_COUNT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmcw_pkg::tmcw_sts_t sts_i,
  output tmcw_pkg::tmcw_ctl_t ctl_o,
  output logic [AW-1:0]       cnt_o
);
  import tmcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_e;

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] FIRST_SRC  = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_ROW_0 = AW'(CELL_COUNT - COLUMNS);

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          rdy_q;
  logic          accept;

  assign accept     = in_valid_i && rdy_q;
  assign in_ready_o = rdy_q;
  assign cnt_o      = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        ctl_o.fill_wr   = 1'b1;
        ctl_o.fill_init = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ctl_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        unique case (sts_i.cmd) inside
          CMD_PUT, CMD_NEWLINE: begin
            if (sts_i.scroll) begin
              cnt_d   = FIRST_SRC;
              state_d = ST_COPY;
            end else begin
              state_d = ST_DONE;
            end
          end
          CMD_CLEAR: begin
            cnt_d   = '0;
            state_d = ST_FILL;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_COPY: begin
        ctl_o.copy_rd = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last copy write lands in this cycle
        cnt_d   = LAST_ROW_0;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        ctl_o.fill_wr = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rdy_q   <= (state_d == ST_IDLE);
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted command not dispatched");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |-> sts_i.out_free)
    else $error("result loaded over a pending result");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_CELL)
    else $error("sweep counter beyond screen");

endmodule

@@ rtl/core/tmcw_dp.sv @@
// datapath of the text-mode console writer: screen memory, cursor,
// scroll copy pipeline and result register; depends on tmcw_pkg
module tmcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELL_COUNT = COLUMNS * ROWS,
  localparam int AW  = $clog2(CELL_COUNT),
  localparam int CLW = $clog2(COLUMNS),
  localparam int RW  = $clog2(ROWS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tmcw_pkg::tmcw_ctl_t                 ctl_i,
  output tmcw_pkg::tmcw_sts_t                 sts_o,
  input  logic [AW-1:0]                       cnt_i,
  input  logic [tmcw_pkg::ATTR_W-1:0]         attr_i,
  input  tmcw_pkg::tmcw_cmd_e                 cmd_i,
  input  logic [tmcw_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tmcw_pkg::ADDR_W-1:0]         read_address_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [tmcw_pkg::POS_W-1:0]          cursor_position_o,
  output logic [tmcw_pkg::COL_W-1:0]          cursor_column_o,
  output logic [tmcw_pkg::ROW_W-1:0]          cursor_row_o,
  output logic [tmcw_pkg::CELL_W-1:0]         read_data_o
);
  import tmcw_pkg::*;

  localparam int XW = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

  // captured command
  tmcw_cmd_e         cmd_q;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] addr_q;

  // cursor, with the row base and linear position kept alongside
  logic [CLW-1:0] col_q;
  logic [RW-1:0]  row_q;
  logic [AW-1:0]  base_q;
  logic [AW-1:0]  pos_q;

  // screen memory and its ports
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic          copy_wr_q;
  logic [AW-1:0] copy_waddr_q;

  logic              out_valid_q;
  logic [POS_W-1:0]  pos_out_q;
  logic [COL_W-1:0]  col_out_q;
  logic [ROW_W-1:0]  row_out_q;
  logic [CELL_W-1:0] data_out_q;

  logic col_last, row_last, in_range, put_wr, line_feed;

  assign col_last  = (col_q == CLW'(COLUMNS - 1));
  assign row_last  = (row_q == RW'(ROWS - 1));
  assign in_range  = (XW'(addr_q) < XW'(CELL_COUNT));
  assign put_wr    = ctl_i.exec && (cmd_q == CMD_PUT);
  assign line_feed = (cmd_q == CMD_NEWLINE) || ((cmd_q == CMD_PUT) && col_last);

  assign sts_o.cmd      = cmd_q;
  assign sts_o.scroll   = row_last && line_feed;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // memory port selection
  always_comb begin
    we    = copy_wr_q || ctl_i.fill_wr || put_wr;
    waddr = pos_q;
    wdata = {attr_i, char_q};
    if (copy_wr_q) begin
      waddr = copy_waddr_q;
      wdata = rdata_q;
    end else if (ctl_i.fill_wr) begin
      waddr = cnt_i;
      wdata = ctl_i.fill_init ? INIT_CELL : {attr_i, SPACE_CODE};
    end
    re    = ctl_i.copy_rd ||
            (ctl_i.exec && (cmd_q == CMD_READ) && in_range);
    raddr = ctl_i.copy_rd ? cnt_i : AW'(addr_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q  <= cmd_i;
      char_q <= char_code_i;
      addr_q <= read_address_i;
    end
    copy_waddr_q <= cnt_i - AW'(COLUMNS);
    if (ctl_i.load_out) begin
      pos_out_q  <= POS_W'(pos_q);
      col_out_q  <= COL_W'(col_q);
      row_out_q  <= ROW_W'(row_q);
      data_out_q <= ((cmd_q == CMD_READ) && in_range) ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      pos_q       <= '0;
      copy_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      copy_wr_q <= ctl_i.copy_rd;
      if (ctl_i.exec && ((cmd_q == CMD_PUT) || (cmd_q == CMD_NEWLINE))) begin
        if (line_feed) begin
          col_q <= '0;
          if (row_last) begin
            pos_q <= base_q;
          end else begin
            row_q  <= row_q + 1'b1;
            base_q <= base_q + AW'(COLUMNS);
            pos_q  <= base_q + AW'(COLUMNS);
          end
        end else begin
          col_q <= col_q + 1'b1;
          pos_q <= pos_q + 1'b1;
        end
      end
      if (ctl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = pos_out_q;
  assign cursor_column_o   = col_out_q;
  assign cursor_row_o      = row_out_q;
  assign read_data_o       = data_out_q;

  a_pos_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == base_q + AW'(col_q))
    else $error("linear cursor out of step with row and column");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= CLW'(COLUMNS - 1)) && (row_q <= RW'(ROWS - 1)))
    else $error("cursor off screen");

  a_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_wr_q |-> !(put_wr || ctl_i.fill_wr))
    else $error("scroll copy write collides with another write");

endmodule

@@ rtl/core/text_mode_console_writer_core.sv @@
// text-mode console writer: cursor-driven character screen with scroll,
// clear and cell read; depends on tmcw_pkg, tmcw_ctrl and tmcw_dp
//
// usage
//   commands enter on the s_axis channel, one result per command leaves on
//   m_axis: the cursor after the command and, for a read, the cell
//   (attribute in the high byte, character in the low byte)
//   the color attribute register sits at APB address 0; pready is tied high
//   and it should be written only while no command is in flight
// timing
//   a command is taken in the idle state, executed in the next cycle and its
//   result is loaded into the output register the cycle after that: a put
//   without scroll, a new line without scroll or a read takes 3 cycles
//   a clear sweeps every cell once: COLUMNS*ROWS + 3 cycles
//   a scroll copies one cell per cycle through the memory read register,
//   then blanks the last row: COLUMNS*ROWS + 4 cycles
// reset
//   after rst_ni releases, a fill pass writes blank cells (0x0720) over the
//   whole screen in COLUMNS*ROWS cycles; s_axis_tready stays low meanwhile
// backpressure
//   the result register holds while m_axis_tready is low; the next command
//   is still accepted and executed, and waits only to load its result
module text_mode_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // apb configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tmcw_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  // command stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // cmd[1:0], char_code[9:2], read_address[20:10], zero[23:21]
  input  logic [tmcw_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // cursor_position[10:0], cursor_column[17:11], cursor_row[22:18],
  // read_data[38:23], zero[39]
  output logic [tmcw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import tmcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);

  logic [ATTR_W-1:0] attr_q;
  logic              reg_hit;

  tmcw_ctl_t     ctl;
  tmcw_sts_t     sts;
  logic [AW-1:0] cnt;

  tmcw_cmd_e         in_cmd;
  logic [POS_W-1:0]  out_pos;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [CELL_W-1:0] out_data;

  // register decode on the word index, byte offset ignored
  assign reg_hit = (paddr[APB_ADDR_W-1] == REG_COLOR);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(32 - ATTR_W){1'b0}}, attr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      attr_q <= pwdata[ATTR_W-1:0];
    end
  end

  // unpack the command transfer
  assign in_cmd = tmcw_cmd_e'(s_axis_tdata[CMD_W-1:0]);

  tmcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .cnt_o      (cnt)
  );

  tmcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .cnt_i             (cnt),
    .attr_i            (attr_q),
    .cmd_i             (in_cmd),
    .char_code_i       (s_axis_tdata[CMD_W +: CHAR_W]),
    .read_address_i    (s_axis_tdata[CMD_W + CHAR_W +: ADDR_W]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .cursor_position_o (out_pos),
    .cursor_column_o   (out_col),
    .cursor_row_o      (out_row),
    .read_data_o       (out_data)
  );

  // pack the result transfer
  assign m_axis_tdata = {1'b0, out_data, out_row, out_col, out_pos};

endmodule

@@ tb/text_mode_console_writer_checker.sv @@
`timescale 1ns / 1ps
// result checker for the text-mode console writer: mirrors screen, cursor and
// color register, predicts each result and compares it; depends on tmcw_pkg
module tmcw_result_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [tmcw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // cmd[1:0], char_code[9:2], read_address[20:10], zero[23:21]
  input  logic [tmcw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cursor_position[10:0], cursor_column[17:11], cursor_row[22:18],
  // read_data[38:23], zero[39]
  input  logic [tmcw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output int unsigned                         error_count,
  output int unsigned                         pending_count
);
  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [APB_ADDR_W-1:0] COLOR_ADDR = {REG_COLOR, 2'b00};

  // same bit order as the result tdata, lowest field last
  typedef struct packed {
    logic [CELL_W-1:0] data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [POS_W-1:0]  pos;
  } cursor_result_t;

  logic [CELL_W-1:0] screen_mirror [CELLS];
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [ATTR_W-1:0] attr_q;
  cursor_result_t    expected_results [$];

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_q, SPACE_CODE};
  endfunction

  // column 0, next row or scroll on the last row
  function automatic void line_feed();
    int k;
    col_q = '0;
    if (int'(row_q) + 1 >= ROWS) begin
      row_q = ROW_W'(ROWS - 1);
      for (k = 0; k + COLUMNS < CELLS; k++) screen_mirror[k] = screen_mirror[k + COLUMNS];
      for (k = CELLS - COLUMNS; k < CELLS; k++) screen_mirror[k] = blank_cell();
    end else begin
      row_q = row_q + 1'b1;
    end
  endfunction

  function automatic cursor_result_t apply_command(tmcw_cmd_e c, logic [CHAR_W-1:0] ch,
                                                   logic [ADDR_W-1:0] addr);
    cursor_result_t r;
    int pos;
    int k;
    r.data = '0;
    case (c)
      CMD_PUT: begin
        pos = int'(row_q) * COLUMNS + int'(col_q);
        screen_mirror[pos] = {attr_q, ch};
        col_q = col_q + 1'b1;
        if (int'(col_q) >= COLUMNS) line_feed();
      end
      CMD_NEWLINE: line_feed();
      CMD_CLEAR: begin
        for (k = 0; k < CELLS; k++) screen_mirror[k] = blank_cell();
      end
      default: begin
        if (int'(addr) < CELLS) r.data = screen_mirror[addr];
      end
    endcase
    pos = int'(row_q) * COLUMNS + int'(col_q);
    r.pos = POS_W'(pos);
    r.col = col_q;
    r.row = row_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cursor_result_t got;
    cursor_result_t want;
    int k;
    if (!rst_ni) begin
      for (k = 0; k < CELLS; k++) screen_mirror[k] = INIT_CELL;
      col_q  = '0;
      row_q  = '0;
      attr_q = ATTR_RESET;
      expected_results.delete();
      error_count = 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == COLOR_ADDR)
        attr_q = pwdata[ATTR_W-1:0];
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          got  = cursor_result_t'(m_axis_tdata[$bits(cursor_result_t)-1:0]);
          want = expected_results.pop_front();
          if (got.pos != want.pos) report_mismatch("cursor_position", got.pos, want.pos);
          if (got.col != want.col) report_mismatch("cursor_column", got.col, want.col);
          if (got.row != want.row) report_mismatch("cursor_row", got.row, want.row);
          if (got.data != want.data) report_mismatch("read_data", got.data, want.data);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_command(tmcw_cmd_e'(s_axis_tdata[1:0]),
                                                 s_axis_tdata[9:2], s_axis_tdata[20:10]));
      pending_count <= expected_results.size();
    end
  end

endmodule

@@ tb/tb_text_mode_console_writer_core.sv @@
`timescale 1ns / 1ps
// testbench top for text_mode_console_writer_core: drives commands, color
// writes and result backpressure; depends on tmcw_pkg and tmcw_result_checker
module tb_text_mode_console_writer_core;
  import tmcw_pkg::*;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = COLUMNS * ROWS;
  localparam int PHASES        = 5;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [APB_ADDR_W-1:0] COLOR_ADDR = {REG_COLOR, 2'b00};
  // the next register slot, which the block does not implement
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_COLOR, 2'b00};

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // cmd[1:0], char_code[9:2], read_address[20:10], zero[23:21]
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // cursor_position[10:0], cursor_column[17:11], cursor_row[22:18],
  // read_data[38:23], zero[39]
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  int unsigned error_count;
  int unsigned pending_count;
  // no idling on either side while set
  logic        calm = 1'b0;
  int          stall_left = 0;

  text_mode_console_writer_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tmcw_result_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hang guard: far beyond a run where every command scrolls and both
  // sides idle for their longest gaps
  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // idle length: mostly short, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if ($urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  // result side backpressure
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left    <= idle_length() - 1;
    end
  end

  // one command transfer; tvalid stays high when no gap follows, so the
  // next command is presented without a break in tvalid
  task automatic send_command(tmcw_cmd_e c, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, addr, ch, c};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = calm ? 0 : sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic release_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  // hold off until the checker has seen every result, then let the block settle;
  // the first look is at the edge after the last transfer so the count is current
  task automatic wait_drained();
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly text with line breaks, some reads (a few past the screen end),
  // rare clears
  task automatic random_command();
    int r;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) addr = ADDR_W'($urandom_range(CELLS, (1 << ADDR_W) - 1));
    else addr = ADDR_W'($urandom_range(0, CELLS - 1));
    if (r < 78) send_command(CMD_PUT, CHAR_W'($urandom_range(0, 255)), addr);
    else if (r < 90) send_command(CMD_READ, CHAR_W'($urandom_range(0, 255)), addr);
    else if (r < 97) send_command(CMD_NEWLINE, CHAR_W'($urandom_range(0, 255)), addr);
    else send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), addr);
  endtask

  initial begin : stimulus
    int phase;
    int i;
    logic [ATTR_W-1:0] attr;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: character extremes, reads of written and blank cells, reads
    // at and past the screen end, new line, clear and reads after it
    send_command(CMD_PUT, 8'h00, '0);
    send_command(CMD_PUT, 8'hFF, '1);
    send_command(CMD_PUT, 8'h55, '0);
    send_command(CMD_READ, 8'h00, 11'd0);
    send_command(CMD_READ, 8'hFF, 11'd1);
    send_command(CMD_READ, 8'h00, 11'd2);
    send_command(CMD_READ, 8'h00, 11'd3);
    send_command(CMD_READ, 8'h00, ADDR_W'(CELLS - 1));
    send_command(CMD_READ, 8'h00, ADDR_W'(CELLS));
    send_command(CMD_READ, 8'h00, '1);
    send_command(CMD_NEWLINE, 8'hAA, '1);
    send_command(CMD_PUT, 8'hAA, '0);
    send_command(CMD_READ, 8'h00, ADDR_W'(COLUMNS));
    send_command(CMD_CLEAR, 8'h00, '0);
    send_command(CMD_READ, 8'h00, 11'd0);
    send_command(CMD_READ, 8'h00, ADDR_W'(COLUMNS));
    send_command(CMD_PUT, 8'h41, '0);
    send_command(CMD_NEWLINE, 8'h00, '0);
    send_command(CMD_READ, 8'h00, ADDR_W'(COLUMNS + 1));
    release_stream();
    wait_drained();

    // random phases, each under its own color; upper data bits are noise
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       attr = 8'h00;
        1:       attr = 8'hFF;
        3:       attr = ATTR_RESET;
        default: attr = ATTR_W'($urandom_range(0, 255));
      endcase
      // a write to the unimplemented slot must leave the color alone
      if (phase == 1) write_reg(SPARE_ADDR, $urandom());
      write_reg(COLOR_ADDR, {24'($urandom()), attr});
      calm <= (phase == 2);
      for (i = 0; i < RANDOM_ITEMS / PHASES; i++) random_command();
      release_stream();
      wait_drained();
    end

    calm <= 1'b0;
    // a trailing clear or scroll has already reported; allow a screen sweep more
    repeat (CELLS + 16) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
